// ===== design/hpf_pkg.sv =====
// ---------------------------------------------------------------------------
// Histogram percentile finder package
// Shared widths, codes and the controller state type.
// ---------------------------------------------------------------------------
`default_nettype none

package hpf_pkg;

    // Number of histogram bins held in the prefix memory.
    localparam int BINS    = 256;
    localparam int ADDR_W  = $clog2(BINS);
    localparam int CNT_W   = $clog2(BINS + 1);

    // Field widths.
    localparam int COUNT_W = 24;
    localparam int TOTAL_W = 32;
    localparam int PCT_W   = 7;
    localparam int IDX_W   = 8;
    localparam int PROD_W  = TOTAL_W + PCT_W;

    // Percentile limits.
    localparam logic [PCT_W-1:0] PCT_MIN  = PCT_W'(1);
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // Transaction modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Query controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/histogram_percentile_finder.sv =====
// Timing: a load is absorbed in the cycle it is accepted and gives no result. A
// query runs ST_ADDR (one read) then ST_CMP (one compare) per binary search step
// (at most 9 steps for 256 bins), or goes straight to ST_DONE for an empty
// histogram; ST_DONE registers the result once the output is free. Throughput:
// one load per cycle while no query is busy; the next query waits for ST_IDLE.
// Reset clears total, bin count, controller and out_valid; memory is not cleared.
// ---------------------------------------------------------------------------
// Histogram percentile finder
// Stores running prefix sums of loaded bins and binary-searches them for the
// first bin whose cumulative count reaches a requested percentile.
// ---------------------------------------------------------------------------
`default_nettype none

module histogram_percentile_finder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         mode,
    input  wire logic                         first_bin,
    input  wire logic [hpf_pkg::COUNT_W-1:0]  bin_count,
    input  wire logic [hpf_pkg::PCT_W-1:0]    percentile,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [hpf_pkg::IDX_W-1:0]         bin_index,
    output logic                              found
);

    // Prefix memory, one synchronous read port and one write port.
    logic [hpf_pkg::TOTAL_W-1:0] prefix_mem [hpf_pkg::BINS];

    hpf_pkg::state_t state_reg, state_next;

    logic [hpf_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [hpf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [hpf_pkg::CNT_W-1:0]   lo_reg, lo_next;
    logic [hpf_pkg::CNT_W-1:0]   hi_reg, hi_next;
    logic [hpf_pkg::CNT_W-1:0]   mid_reg, mid_next;
    logic [hpf_pkg::PROD_W-1:0]  thr_reg, thr_next;
    logic                        res_found_reg, res_found_next;
    logic                        out_valid_reg, out_valid_next;
    logic [hpf_pkg::IDX_W-1:0]   bin_index_reg, bin_index_next;
    logic                        found_reg, found_next;
    logic [hpf_pkg::TOTAL_W-1:0] rdata_reg;

    logic                        in_acc;
    logic                        out_free;
    logic                        wr_en;
    logic [hpf_pkg::ADDR_W-1:0]  wr_addr;
    logic [hpf_pkg::TOTAL_W-1:0] wr_data;
    logic                        rd_en;
    logic [hpf_pkg::CNT_W-1:0]   mid_calc;
    logic [hpf_pkg::TOTAL_W-1:0] base_total;
    logic [hpf_pkg::CNT_W-1:0]   base_cnt;
    logic [hpf_pkg::TOTAL_W:0]   sum_wide;
    logic [hpf_pkg::TOTAL_W-1:0] sum_sat;
    logic [hpf_pkg::PCT_W-1:0]   pct_clamped;
    logic                        query_empty;
    logic [hpf_pkg::PROD_W-1:0]  prod;
    logic                        hit;
    logic [hpf_pkg::CNT_W-1:0]   lo_step;
    logic [hpf_pkg::CNT_W-1:0]   hi_step;

    // Handshake.
    assign in_stall  = (state_reg != hpf_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign found     = found_reg;

    // Load arithmetic: restart handling and saturating accumulation.
    assign base_total = first_bin ? '0 : total_reg;
    assign base_cnt   = first_bin ? '0 : cnt_reg;
    assign sum_wide   = {1'b0, base_total} + (hpf_pkg::TOTAL_W + 1)'(bin_count);
    assign sum_sat    = sum_wide[hpf_pkg::TOTAL_W] ? '1 : sum_wide[hpf_pkg::TOTAL_W-1:0];

    // Query setup: clamp the percentile and detect an empty histogram.
    always_comb
    begin
        if (percentile < hpf_pkg::PCT_MIN)
        begin
            pct_clamped = hpf_pkg::PCT_MIN;
        end
        else if (percentile > hpf_pkg::PCT_FULL)
        begin
            pct_clamped = hpf_pkg::PCT_FULL;
        end
        else
        begin
            pct_clamped = percentile;
        end
    end

    assign query_empty = (total_reg == '0) || (cnt_reg == '0);

    // One binary search step: midpoint, scaled prefix and narrowed bounds.
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prod     = hpf_pkg::PROD_W'(rdata_reg) * hpf_pkg::PROD_W'(hpf_pkg::PCT_FULL);
    assign hit      = (prod >= thr_reg);
    assign lo_step  = hit ? lo_reg : (mid_reg + hpf_pkg::CNT_W'(1));
    assign hi_step  = hit ? mid_reg : hi_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpf_pkg::ST_IDLE:
            begin
                if (in_acc && (mode == hpf_pkg::MODE_QUERY))
                begin
                    state_next = query_empty ? hpf_pkg::ST_DONE : hpf_pkg::ST_ADDR;
                end
            end
            hpf_pkg::ST_ADDR:
            begin
                state_next = hpf_pkg::ST_CMP;
            end
            hpf_pkg::ST_CMP:
            begin
                state_next = (lo_step < hi_step) ? hpf_pkg::ST_ADDR : hpf_pkg::ST_DONE;
            end
            hpf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = hpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hpf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register next values.
    always_comb
    begin
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        thr_next       = thr_reg;
        res_found_next = res_found_reg;
        wr_en          = 1'b0;
        wr_addr        = base_cnt[hpf_pkg::ADDR_W-1:0];
        wr_data        = sum_sat;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        bin_index_next = bin_index_reg;
        found_next     = found_reg;

        case (state_reg)
            hpf_pkg::ST_IDLE:
            begin
                if (in_acc && (mode == hpf_pkg::MODE_LOAD))
                begin
                    total_next = base_total;
                    cnt_next   = base_cnt;
                    if (base_cnt < hpf_pkg::CNT_W'(hpf_pkg::BINS))
                    begin
                        wr_en      = 1'b1;
                        total_next = sum_sat;
                        cnt_next   = base_cnt + hpf_pkg::CNT_W'(1);
                    end
                end
                else if (in_acc)
                begin
                    lo_next        = '0;
                    hi_next        = cnt_reg;
                    thr_next       = hpf_pkg::PROD_W'(total_reg)
                                     * hpf_pkg::PROD_W'(pct_clamped);
                    res_found_next = 1'b0;
                end
            end
            hpf_pkg::ST_ADDR:
            begin
                rd_en    = 1'b1;
                mid_next = mid_calc;
            end
            hpf_pkg::ST_CMP:
            begin
                lo_next        = lo_step;
                hi_next        = hi_step;
                res_found_next = (lo_step < cnt_reg);
            end
            hpf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    bin_index_next = res_found_reg ? hpf_pkg::IDX_W'(lo_reg) : '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // Prefix memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= prefix_mem[mid_calc[hpf_pkg::ADDR_W-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpf_pkg::ST_IDLE;
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search and payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        thr_reg       <= thr_next;
        res_found_reg <= res_found_next;
        bin_index_reg <= bin_index_next;
        found_reg     <= found_next;
    end

endmodule

`default_nettype wire

// ===== design/hpf_checker.sv =====
// ---------------------------------------------------------------------------
// Histogram percentile finder port checker
// Watches the top-level ports for output and query sequencing rules.
// ---------------------------------------------------------------------------
`default_nettype none

module hpf_port_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         mode,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [hpf_pkg::IDX_W-1:0]    bin_index,
    input wire logic                         found
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_index) && $stable(found))
        else $error("result changed while stalled");

    // A miss always reports bin zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> bin_index == '0)
        else $error("miss with nonzero bin index");

    // An accepted query occupies the block in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == hpf_pkg::MODE_QUERY) |=> in_stall)
        else $error("block free right after a query");

    // A new result only appears after the search held the input side.
    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a query in progress");

endmodule

bind histogram_percentile_finder hpf_port_checker u_hpf_checker (.*);

`default_nettype wire

// ===== test/hpf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram percentile finder checker
// Watches both channels. It keeps its own copy of the prefix sums, predicts
// the answer for every accepted query, and compares each accepted result
// field by field against the oldest outstanding answer.
// ---------------------------------------------------------------------------

module hpf_checker
    import hpf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               mode,
    input  wire logic               first_bin,
    input  wire logic [COUNT_W-1:0] bin_count,
    input  wire logic [PCT_W-1:0]   percentile,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [IDX_W-1:0]   bin_index,
    input  wire logic               found,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             hit;
    } answer_t;

    // Shadow histogram state.
    logic [TOTAL_W-1:0] cum_counts [BINS];
    logic [TOTAL_W-1:0] pixel_total;
    int                 bins_held;

    // Answers owed by the block, oldest first.
    answer_t answers_due [$];

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: hpf mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // First loaded bin whose cumulative count times 100 reaches pct times the
    // total. Out-of-range percentiles are pulled into 1..100.
    function automatic answer_t find_bin(input logic [PCT_W-1:0] pct_raw);
        logic [PCT_W-1:0] pct;
        logic [63:0]      goal;
        answer_t          ans;
        if (pct_raw < PCT_MIN)
            pct = PCT_MIN;
        else if (pct_raw > PCT_FULL)
            pct = PCT_FULL;
        else
            pct = pct_raw;
        goal = 64'(pct) * 64'(pixel_total);
        ans  = '0;
        if (pixel_total != '0)
        begin
            for (int k = 0; k < bins_held; k++)
            begin
                if (!ans.hit && (64'(cum_counts[k]) * 64'(PCT_FULL) >= goal))
                begin
                    ans.idx = IDX_W'(k);
                    ans.hit = 1'b1;
                end
            end
        end
        return ans;
    endfunction

    // Compare finished transactions first, then absorb new input transactions.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t           want;
        logic [TOTAL_W:0]  wide_sum;
        if (!rst_n)
        begin
            pixel_total = '0;
            bins_held   = 0;
            answers_due.delete();
            pending     = 0;
        end
        else
        begin
            // Result side.
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with no query waiting (bin_index %0d found %0b)",
                                              bin_index, found));
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (found !== want.hit)
                        report_mismatch($sformatf("found expected %0b got %0b",
                                                  want.hit, found));
                    if (bin_index !== want.idx)
                        report_mismatch($sformatf("bin_index expected %0d got %0d",
                                                  want.idx, bin_index));
                end
            end

            // Input side.
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_LOAD)
                begin
                    if (first_bin)
                    begin
                        pixel_total = '0;
                        bins_held   = 0;
                    end
                    // Loads past the last bin are dropped.
                    if (bins_held < BINS)
                    begin
                        wide_sum    = {1'b0, pixel_total} + (TOTAL_W + 1)'(bin_count);
                        pixel_total = wide_sum[TOTAL_W] ? '1 : wide_sum[TOTAL_W-1:0];
                        cum_counts[bins_held] = pixel_total;
                        bins_held++;
                    end
                end
                else
                begin
                    answers_due.push_back(find_bin(percentile));
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== test/tb_histogram_percentile_finder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram percentile finder testbench
// Loads histograms of many shapes and lengths, including a full one with
// surplus bins, and queries percentiles across and beyond 1..100, with
// random gaps on the input side and random stalls on the result side.
// ---------------------------------------------------------------------------

module tb_histogram_percentile_finder;

    import hpf_pkg::*;

    localparam int ITEM_GOAL   = 1150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 30;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               mode       = MODE_LOAD;
    logic               first_bin  = 1'b0;
    logic [COUNT_W-1:0] bin_count  = '0;
    logic [PCT_W-1:0]   percentile = PCT_MIN;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [IDX_W-1:0]   bin_index;
    logic               found;

    logic in_taken   = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   shadow_bins = 0;
    bit   calm        = 1'b0;

    // Result side stall generator state.
    int sink_phase_left = 0;
    bit sink_quiet      = 1'b0;
    int stall_run       = 0;
    bit stall_level     = 1'b0;

    histogram_percentile_finder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .first_bin  (first_bin),
        .bin_count  (bin_count),
        .percentile (percentile),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .found      (found)
    );

    hpf_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .first_bin  (first_bin),
        .bin_count  (bin_count),
        .percentile (percentile),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .found      (found),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Free-running 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note each input transaction accepted at a rising edge.
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_histogram_percentile_finder: errors");
            $finish;
        end
    end

    // Result side stalls: bursts of mixed length, with quiet phases in between.
    always @(negedge clk)
    begin
        int r;
        if (sink_phase_left == 0)
        begin
            sink_quiet      = ($urandom_range(0, 3) == 0);
            sink_phase_left = $urandom_range(100, 400);
        end
        sink_phase_left--;
        if (stall_run == 0)
        begin
            stall_level = !sink_quiet && ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                stall_run = $urandom_range(1, 3);
            else if (r < 95)
                stall_run = $urandom_range(4, 10);
            else
                stall_run = $urandom_range(20, 40);
        end
        stall_run--;
        out_stall <= stall_level;
    end

    // Input gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Percentile: mostly in range, sometimes anything the field can carry.
    function automatic logic [PCT_W-1:0] pick_pct();
        if ($urandom_range(0, 9) == 0)
            return PCT_W'($urandom_range(0, 127));
        else
            return PCT_W'($urandom_range(1, 100));
    endfunction

    // Bin count drawn according to the shape of the current histogram.
    function automatic logic [COUNT_W-1:0] pick_count(input int shape);
        int r;
        r = $urandom_range(0, 9);
        case (shape)
            0:       return (r < 7) ? '0 : COUNT_W'($urandom_range(1, 15));
            1:       return COUNT_W'($urandom());
            2:       return (r < 6) ? '1 : COUNT_W'($urandom());
            default:
            begin
                if (r < 3)
                    return '0;
                else if (r < 6)
                    return COUNT_W'($urandom_range(0, 15));
                else if (r < 9)
                    return COUNT_W'($urandom());
                else
                    return '1;
            end
        endcase
    endfunction

    // Drive one input transaction at a falling edge and wait until it is taken.
    task automatic push_item(input logic m, input logic fb,
                             input logic [COUNT_W-1:0] cnt, input logic [PCT_W-1:0] pct);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        first_bin  <= fb;
        bin_count  <= cnt;
        percentile <= pct;
        do
            @(negedge clk);
        while (!in_taken);
        // Loads beyond the last bin are ignored and not counted.
        if (m == MODE_LOAD)
        begin
            if (fb)
                shadow_bins = 0;
            if (shadow_bins < BINS)
            begin
                shadow_bins++;
                items_sent++;
            end
        end
        else
        begin
            items_sent++;
        end
    endtask

    task automatic load_bin(input logic fb, input logic [COUNT_W-1:0] cnt);
        push_item(MODE_LOAD, fb, cnt, PCT_W'($urandom_range(1, 100)));
    endtask

    task automatic ask_pct(input logic [PCT_W-1:0] pct);
        push_item(MODE_QUERY, logic'($urandom_range(0, 1)), COUNT_W'($urandom()), pct);
    endtask

    // Hold off input until every outstanding answer has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int set_len;
        int shape;
        int full_sets;
        int n_q;
        logic fb;

        full_sets = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty histogram straight after reset.
        ask_pct(PCT_W'(50));

        // Directed: loading without a restart flag after reset, count extremes.
        load_bin(1'b0, COUNT_W'(5));
        load_bin(1'b0, '0);
        load_bin(1'b0, '1);
        load_bin(1'b0, COUNT_W'(1));
        ask_pct(PCT_MIN);
        ask_pct(PCT_FULL);
        ask_pct(PCT_W'(0));
        ask_pct(PCT_W'(127));
        ask_pct(PCT_W'(50));
        ask_pct(PCT_W'(64));

        // Directed: restart into a histogram with no pixels.
        load_bin(1'b1, '0);
        load_bin(1'b0, '0);
        load_bin(1'b0, '0);
        ask_pct(PCT_W'(30));

        // Directed: single-bin histogram.
        load_bin(1'b1, COUNT_W'(7));
        ask_pct(PCT_MIN);
        ask_pct(PCT_FULL);

        // Directed: alternating bit patterns.
        load_bin(1'b1, COUNT_W'(24'hAAAAAA));
        load_bin(1'b0, COUNT_W'(24'h555555));
        ask_pct(PCT_W'(99));
        ask_pct(PCT_W'(67));

        drain_results();

        // Random histograms, the first one full with surplus bins.
        while (items_sent < ITEM_GOAL)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 29) == 0)
                drain_results();
            if (full_sets == 0 || (full_sets < 3 && $urandom_range(0, 24) == 0))
            begin
                set_len = BINS + $urandom_range(1, 4);
                full_sets++;
            end
            else
            begin
                set_len = $urandom_range(1, 24);
            end
            shape = $urandom_range(0, 3);
            for (int b = 0; b < set_len; b++)
            begin
                // Occasional query against a partly loaded histogram.
                if (b > 0 && $urandom_range(0, 7) == 0)
                    ask_pct(pick_pct());
                if (b == 0)
                    fb = ($urandom_range(0, 9) != 0);
                else
                    fb = ($urandom_range(0, 149) == 0);
                load_bin(fb, pick_count(shape));
            end
            n_q = $urandom_range(1, 6);
            repeat (n_q) ask_pct(pick_pct());
        end

        // Let every answer come back, then allow for late strays.
        drain_results();
        repeat (DRAIN_WAIT) @(negedge clk);

        if (fail_count == 0)
            $display("tb_histogram_percentile_finder: clean");
        else
            $display("tb_histogram_percentile_finder: errors");
        $finish;
    end

endmodule
